// ===== design/dnsq_pkg.sv =====
package dnsq_pkg;

    localparam int MV_W          = 16;
    localparam int PCT_W         = 7;
    localparam int CONFIRM_W     = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int COUNT_BITS_DEF = 8;

    // Divider geometry: numerator 200*d + span fits 24 bits, divisor 2*span fits 18.
    localparam int SPAN_W = MV_W + 1;
    localparam int DEN_W  = SPAN_W + 1;
    localparam int NUM_W  = 24;
    localparam int QUO_W  = 7;

    localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
    localparam logic [7:0]       SCALE_MULT = 8'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_LEVEL   = 3'd0,
        REG_BRIGHT_LEVEL = 3'd1,
        REG_NIGHT_THRESH = 3'd2,
        REG_DAY_THRESH   = 3'd3,
        REG_CONFIRM      = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DEC_NONE  = 2'd0,
        DEC_DAY   = 2'd1,
        DEC_NIGHT = 2'd2,
        DEC_DEFER = 2'd3
    } decision_t;

    localparam logic MODE_DAY   = 1'b0;
    localparam logic MODE_NIGHT = 1'b1;

    localparam logic [MV_W-1:0]      DARK_RESET    = 16'd0;
    localparam logic [MV_W-1:0]      BRIGHT_RESET  = 16'd3300;
    localparam logic [PCT_W-1:0]     NIGHT_RESET   = 7'd20;
    localparam logic [PCT_W-1:0]     DAY_RESET     = 7'd40;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input item
        logic load;      // set up numerator and divisor
        logic div_first; // first divide step, also checks saturation
        logic div_step;  // one restoring divide step
        logic decide;    // update mode state and write the result register
    } dnsq_cmd_t;

endpackage

// ===== design/dnsq_ctrl.sv =====
module dnsq_ctrl
    import dnsq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output dnsq_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_DIV    = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    localparam logic [2:0] LAST_STEP = 3'(QUO_W - 1);

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == 3'd0);
                step_next     = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // hold until the result register can take the item
                if (slot_free)
                begin
                    cmd.decide     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/dnsq_datapath.sv =====
module dnsq_datapath
    import dnsq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dnsq_cmd_t             cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [MV_W-1:0]       millivolts,
    input  logic                  sample_valid,
    input  logic                  lens_busy,
    output logic [1:0]            decision,
    output logic [PCT_W-1:0]      light_percent,
    output logic                  current_mode,
    output logic                  pending_flag,
    output logic                  pending_mode
);

    localparam int CMP_W = (COUNT_BITS > CONFIRM_W) ? COUNT_BITS : CONFIRM_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // configuration
    logic [MV_W-1:0]      dark_reg, bright_reg;
    logic [PCT_W-1:0]     night_reg, day_reg;
    logic [CONFIRM_W-1:0] confirm_reg;

    // captured item
    logic [MV_W-1:0] mv_reg;
    logic            sv_reg, busy_reg;

    // divider
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_sh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             low_reg, sat_reg;

    // mode state
    logic                  mode_reg, mode_next;
    logic                  target_reg, target_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  pend_reg, pend_next;
    logic                  pend_tgt_reg, pend_tgt_next;

    // result register
    logic [1:0]       dec_reg;
    logic [PCT_W-1:0] pct_reg;
    logic             mode_out_reg, pend_out_reg, pend_tgt_out_reg;

    // setup
    logic [SPAN_W-1:0] dark_p1, bright_ext, bright_eff, span;
    logic [MV_W-1:0]   diff;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic              low;

    always_comb
    begin
        dark_p1    = {1'b0, dark_reg} + SPAN_W'(1);
        bright_ext = {1'b0, bright_reg};
        bright_eff = (bright_ext < dark_p1) ? dark_p1 : bright_ext;
        span       = bright_eff - {1'b0, dark_reg};
        low        = (mv_reg <= dark_reg);
        diff       = mv_reg - dark_reg;
        num        = NUM_W'(diff) * NUM_W'(SCALE_MULT) + NUM_W'(span);
        den        = {span, 1'b0};
    end

    logic                ge;
    logic [NUM_W:0]      sat_limit;
    logic                sat_now;

    assign ge        = (rem_reg >= den_sh_reg);
    assign sat_limit = {den_sh_reg, 1'b0};
    assign sat_now   = ({1'b0, rem_reg} >= sat_limit);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mv_reg   <= millivolts;
            sv_reg   <= sample_valid;
            busy_reg <= lens_busy;
        end
        if (cmd.load)
        begin
            rem_reg    <= num;
            den_sh_reg <= NUM_W'({den, 6'b0});
            low_reg    <= low;
            quo_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            // saturation uses the remainder before any subtraction
            if (cmd.div_first)
            begin
                sat_reg <= sat_now;
            end
            if (ge)
            begin
                rem_reg <= rem_reg - den_sh_reg;
            end
            den_sh_reg <= den_sh_reg >> 1;
            quo_reg    <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    // decision
    logic [PCT_W-1:0]      pct;
    logic                  is_night, is_day, cand;
    logic [COUNT_BITS-1:0] run_new;
    logic                  confirmed;
    decision_t             dec;

    always_comb
    begin
        if (!sv_reg || low_reg)
        begin
            pct = '0;
        end
        else if (sat_reg || (quo_reg > PCT_FULL))
        begin
            pct = PCT_FULL;
        end
        else
        begin
            pct = quo_reg;
        end

        is_night = (pct <= night_reg);
        is_day   = (pct >= day_reg);
        cand     = is_night ? MODE_NIGHT : MODE_DAY;

        if ((cand == target_reg) && (count_reg != '0))
        begin
            run_new = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_ONE;
        end
        else
        begin
            run_new = CNT_ONE;
        end
        confirmed = (CMP_W'(run_new) >= CMP_W'(confirm_reg));

        mode_next     = mode_reg;
        target_next   = target_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        pend_tgt_next = pend_tgt_reg;
        dec           = DEC_NONE;

        if (!sv_reg || !(is_night || is_day))
        begin
            count_next = '0;
        end
        else if (cand == mode_reg)
        begin
            count_next = '0;
            pend_next  = 1'b0;
        end
        else
        begin
            target_next = cand;
            count_next  = run_new;
            if (confirmed)
            begin
                count_next = '0;
                if (busy_reg)
                begin
                    pend_next     = 1'b1;
                    pend_tgt_next = cand;
                    dec           = DEC_DEFER;
                end
                else
                begin
                    mode_next = cand;
                    pend_next = 1'b0;
                    dec       = (cand == MODE_NIGHT) ? DEC_NIGHT : DEC_DAY;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            dec_reg          <= dec;
            pct_reg          <= pct;
            mode_out_reg     <= mode_next;
            pend_out_reg     <= pend_next;
            pend_tgt_out_reg <= pend_tgt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_DAY;
            target_reg   <= MODE_DAY;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_tgt_reg <= MODE_DAY;
        end
        else if (cmd.decide)
        begin
            mode_reg     <= mode_next;
            target_reg   <= target_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            pend_tgt_reg <= pend_tgt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg    <= DARK_RESET;
            bright_reg  <= BRIGHT_RESET;
            night_reg   <= NIGHT_RESET;
            day_reg     <= DAY_RESET;
            confirm_reg <= CONFIRM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DARK_LEVEL:   dark_reg    <= cfg_data;
                REG_BRIGHT_LEVEL: bright_reg  <= cfg_data;
                REG_NIGHT_THRESH: night_reg   <= cfg_data[PCT_W-1:0];
                REG_DAY_THRESH:   day_reg     <= cfg_data[PCT_W-1:0];
                REG_CONFIRM:      confirm_reg <= cfg_data[CONFIRM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign decision      = dec_reg;
    assign light_percent = pct_reg;
    assign current_mode  = mode_out_reg;
    assign pending_flag  = pend_out_reg;
    assign pending_mode  = pend_tgt_out_reg;

endmodule

// ===== design/day_night_switch_qualifier.sv =====
// A result is written to the output register after its item is accepted, by a
// setup step, 7 restoring divide steps, then the decision that writes the result
// register; the decision holds while the output register is full. A new item is
// accepted only when the controller is idle, after the previous item is decided.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low): calibration registers return to their
// defaults, mode is day, run count and pending switch are cleared, no result is valid.
module day_night_switch_qualifier
    import dnsq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MV_W-1:0]       millivolts,
    input  logic                  sample_valid,
    input  logic                  lens_busy,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            decision,
    output logic [PCT_W-1:0]      light_percent,
    output logic                  current_mode,
    output logic                  pending_flag,
    output logic                  pending_mode
);

    dnsq_cmd_t cmd;

    // Sequence each item: capture, set up numerator and divisor, divide, decide.
    dnsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Scale the reading to a percent with a sequential shift-subtract divider, then
    // apply the hysteresis thresholds and the confirmation run count.
    dnsq_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .millivolts    (millivolts),
        .sample_valid  (sample_valid),
        .lens_busy     (lens_busy),
        .decision      (decision),
        .light_percent (light_percent),
        .current_mode  (current_mode),
        .pending_flag  (pending_flag),
        .pending_mode  (pending_mode)
    );

    // An accepted item keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // The percent never exceeds full scale.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> light_percent <= PCT_FULL)
        else $error("light percent above full scale");

    // A deferred switch always leaves a pending switch behind.
    a_defer_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decision == DEC_DEFER |-> pending_flag)
        else $error("deferred decision without pending switch");

    // A direct switch clears the pending switch and lands on its target mode.
    a_switch_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (decision == DEC_DAY || decision == DEC_NIGHT)
        |-> !pending_flag && (current_mode == (decision == DEC_NIGHT)))
        else $error("switch decision disagrees with mode or pending flag");

endmodule
